// ----- rtl/wide_decimal_string_to_int_core_assert.svh -----
// Assertion macros shared by the string-to-integer core.
// Depends on nothing; included by modules that carry assertions.
`ifndef WIDE_DECIMAL_STRING_TO_INT_CORE_ASSERT_SVH
`define WIDE_DECIMAL_STRING_TO_INT_CORE_ASSERT_SVH

// Same-cycle implication, quiet during reset
`define WDSI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wdsi same-cycle check failed");

// Next-cycle implication, quiet during reset
`define WDSI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wdsi next-cycle check failed");

`endif

// ----- rtl/wdsi_pkg.sv -----
// Shared types, code-unit tables and the classifier function of the string-to-integer core.
// No dependencies.
package wdsi_pkg;

   localparam int NUM_DIGIT_BLOCKS = 18;
   localparam int NUM_SPACE_UNITS  = 26;

   // First code unit (digit zero) of each block of ten decimal digits
   localparam logic [15:0] DIGIT_BASE [NUM_DIGIT_BLOCKS] = '{
      16'h0030, 16'h0660, 16'h06F0, 16'h0966, 16'h09E6, 16'h0A66, 16'h0AE6, 16'h0B66,
      16'h0C66, 16'h0CE6, 16'h0D66, 16'h0E50, 16'h0ED0, 16'h0F20, 16'h1040, 16'h17E0,
      16'h1810, 16'hFF10
   };

   // Leading whitespace units that are skipped
   localparam logic [15:0] SPACE_UNIT [NUM_SPACE_UNITS] = '{
      16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h0020, 16'h0085, 16'h00A0,
      16'h1680, 16'h180E, 16'h2000, 16'h2001, 16'h2002, 16'h2003, 16'h2004, 16'h2005,
      16'h2006, 16'h2007, 16'h2008, 16'h2009, 16'h200A, 16'h2028, 16'h2029, 16'h202F,
      16'h205F, 16'h3000
   };

   localparam logic [15:0] CODE_NUL   = 16'h0000;
   localparam logic [15:0] CODE_PLUS  = 16'h002B;
   localparam logic [15:0] CODE_MINUS = 16'h002D;

   localparam logic [32:0] ACC_CAP    = 33'h1_0000_0000;
   localparam logic [32:0] NEG_LIMIT  = 33'h0_8000_0000;
   localparam logic [32:0] POS_LIMIT  = 33'h0_7FFF_FFFF;
   localparam logic [31:0] RESULT_MIN = 32'h8000_0000;
   localparam logic [31:0] RESULT_MAX = 32'h7FFF_FFFF;

   typedef enum logic [2:0] {
      PHASE_SKIP   = 3'b001,
      PHASE_DIGITS = 3'b010,
      PHASE_DONE   = 3'b100
   } phase_type;

   // Decoded form of one code unit
   typedef struct packed {
      logic       is_nul;
      logic       is_space;
      logic       is_minus;
      logic       is_plus;
      logic       is_digit;
      logic [3:0] digit;
   } unit_class_type;

   function automatic unit_class_type classify(input logic [15:0] unit_code);
      unit_class_type c;
      logic [15:0]    off;
      c          = '0;
      c.is_nul   = (unit_code == CODE_NUL);
      c.is_minus = (unit_code == CODE_MINUS);
      c.is_plus  = (unit_code == CODE_PLUS);
      for (int k = 0; k < NUM_SPACE_UNITS; k++) begin
         if (unit_code == SPACE_UNIT[k]) c.is_space = 1'b1;
      end
      // Blocks do not overlap, so at most one offset lands in 0..9
      for (int k = 0; k < NUM_DIGIT_BLOCKS; k++) begin
         off = unit_code - DIGIT_BASE[k];
         if (off <= 16'd9) begin
            c.is_digit = 1'b1;
            c.digit    = off[3:0];
         end
      end
      return c;
   endfunction

endpackage

// ----- rtl/wdsi_decode.sv -----
// Input register stage: accepts a request and holds its classified code unit.
// Depends on wdsi_pkg.
module wdsi_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [15:0]             req_code_unit,
   output logic                    stage_valid,
   output wdsi_pkg::unit_class_type stage_class,
   input  logic                    stage_take
);

   logic                     valid_ff, valid_in;
   wdsi_pkg::unit_class_type class_ff;
   logic                     req_fire;

   // Stage frees up when the accumulator takes its contents
   assign req_ready = !valid_ff || stage_take;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      if (req_fire) begin
         valid_in = 1'b1;
      end else if (stage_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload: classification done on the way in
   always_ff @(posedge clock) begin
      if (req_fire) begin
         class_ff <= wdsi_pkg::classify(req_code_unit);
      end
   end

   assign stage_valid = valid_ff;
   assign stage_class = class_ff;

endmodule

// ----- rtl/wdsi_accum.sv -----
// Parse state (phase, sign, capped magnitude) and the registered result.
// Depends on wdsi_pkg and wide_decimal_string_to_int_core_assert.svh.
`include "wide_decimal_string_to_int_core_assert.svh"

module wdsi_accum (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     stage_valid,
   input  wdsi_pkg::unit_class_type stage_class,
   output logic                     stage_take,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [31:0]       rsp_value
);

   wdsi_pkg::phase_type phase_ff, phase_in;
   logic                neg_ff, neg_in;
   logic [32:0]         acc_ff, acc_in;
   logic                out_valid_ff, out_valid_in;
   logic signed [31:0]  value_ff;
   logic [31:0]         result;
   logic [35:0]         acc_times_ten;
   logic [32:0]         acc_next_digit;
   logic                out_free;
   logic                take_nul;

   // Only a terminator needs room in the output register
   assign out_free   = !out_valid_ff || rsp_ready;
   assign stage_take = stage_valid && (!stage_class.is_nul || out_free);
   assign take_nul   = stage_take && stage_class.is_nul;

   // acc*10 + digit, held at the cap
   assign acc_times_ten = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} + {32'd0, stage_class.digit};
   assign acc_next_digit = (acc_times_ten >= {3'b000, wdsi_pkg::ACC_CAP}) ?
                           wdsi_pkg::ACC_CAP : acc_times_ten[32:0];

   // Saturated result from the current state
   always_comb begin
      if (neg_ff) begin
         result = (acc_ff >= wdsi_pkg::NEG_LIMIT) ? wdsi_pkg::RESULT_MIN
                                                  : (~acc_ff[31:0]) + 32'd1;
      end else begin
         result = (acc_ff > wdsi_pkg::POS_LIMIT) ? wdsi_pkg::RESULT_MAX : acc_ff[31:0];
      end
   end

   // Next parse state
   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      if (stage_take) begin
         if (stage_class.is_nul) begin
            phase_in = wdsi_pkg::PHASE_SKIP;
            neg_in   = 1'b0;
            acc_in   = '0;
         end else begin
            case (phase_ff)
               wdsi_pkg::PHASE_SKIP: begin
                  if (stage_class.is_space) begin
                     phase_in = wdsi_pkg::PHASE_SKIP;
                  end else if (stage_class.is_minus) begin
                     neg_in   = 1'b1;
                     phase_in = wdsi_pkg::PHASE_DIGITS;
                  end else if (stage_class.is_plus) begin
                     phase_in = wdsi_pkg::PHASE_DIGITS;
                  end else if (stage_class.is_digit) begin
                     acc_in   = acc_next_digit;
                     phase_in = wdsi_pkg::PHASE_DIGITS;
                  end else begin
                     phase_in = wdsi_pkg::PHASE_DONE;
                  end
               end
               wdsi_pkg::PHASE_DIGITS: begin
                  if (stage_class.is_digit) begin
                     acc_in = acc_next_digit;
                  end else begin
                     phase_in = wdsi_pkg::PHASE_DONE;
                  end
               end
               default: begin
                  phase_in = wdsi_pkg::PHASE_DONE;
               end
            endcase
         end
      end
   end

   // Output register valid
   always_comb begin
      if (take_nul) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wdsi_pkg::PHASE_SKIP;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_nul) begin
         value_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_value = value_ff;

   // Magnitude never passes the cap
   `WDSI_ASSERT_NOW(a_acc_capped, clock, reset, 1'b1, acc_ff <= wdsi_pkg::ACC_CAP)
   // While skipping whitespace nothing has been recorded yet
   `WDSI_ASSERT_NOW(a_skip_clean, clock, reset, phase_ff == wdsi_pkg::PHASE_SKIP,
                    acc_ff == 33'd0 && !neg_ff)
   // A terminator is never taken over an unread result
   `WDSI_ASSERT_NOW(a_no_overwrite, clock, reset, take_nul, !out_valid_ff || rsp_ready)
   // A terminator restarts the parse and presents a result
   `WDSI_ASSERT_NEXT(a_nul_restart, clock, reset, take_nul,
                     phase_ff == wdsi_pkg::PHASE_SKIP && acc_ff == 33'd0 && out_valid_ff)

endmodule

// ----- rtl/wide_decimal_string_to_int_core.sv -----
// Path: a request is held in the input register; a terminator then loads its result into the output register.
// Throughput: one code unit per cycle unless a terminator stalls; the state update acc*10+digit is combinational.
// A terminator stalls only while the output register still holds an unread result.
// Reset: synchronous, active high; clears the parse state and both valid flags.
// Top level of the UTF-16 decimal string to saturated int32 parser.
// Depends on wdsi_pkg, wdsi_decode and wdsi_accum.
module wide_decimal_string_to_int_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_code_unit,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value
);

   logic                     stage_valid;
   logic                     stage_take;
   wdsi_pkg::unit_class_type stage_class;

   // Input register with code-unit classification
   wdsi_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_unit (req_code_unit),
      .stage_valid   (stage_valid),
      .stage_class   (stage_class),
      .stage_take    (stage_take)
   );

   // Parse state and result register
   wdsi_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_class (stage_class),
      .stage_take  (stage_take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_value   (rsp_value)
   );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for wide_decimal_string_to_int_core: UTF-16 strings in, saturated int32 out.
// Depends on wdsi_pkg and the core RTL; holds its own parser model in a small scoreboard class.
module tb_top;

   // Tracks the parse of the request stream and the int32 values it must yield
   class parse_checker;
      wdsi_pkg::phase_type parse_phase;
      bit                  minus_seen;
      logic [32:0]         magnitude;
      logic [31:0]         pending_values[$];
      int unsigned         mismatch_count;

      function new();
         clear_parse();
         mismatch_count = 0;
      endfunction

      function void clear_parse();
         parse_phase = wdsi_pkg::PHASE_SKIP;
         minus_seen  = 1'b0;
         magnitude   = '0;
      endfunction

      // Digit 0..9 from any of the ten-unit digit blocks, -1 otherwise
      function int digit_value(logic [15:0] unit_code);
         logic [15:0] off;
         for (int k = 0; k < wdsi_pkg::NUM_DIGIT_BLOCKS; k++) begin
            off = unit_code - wdsi_pkg::DIGIT_BASE[k];
            if (off <= 16'd9) return int'(off);
         end
         return -1;
      endfunction

      function bit is_blank(logic [15:0] unit_code);
         for (int k = 0; k < wdsi_pkg::NUM_SPACE_UNITS; k++)
            if (unit_code == wdsi_pkg::SPACE_UNIT[k]) return 1'b1;
         return 1'b0;
      endfunction

      // magnitude*10 + digit, held at 2^32
      function void add_digit(int d);
         logic [36:0] wide;
         wide      = {4'b0, magnitude} * 37'd10 + 37'(d);
         magnitude = (wide >= {4'b0, wdsi_pkg::ACC_CAP}) ? wdsi_pkg::ACC_CAP : wide[32:0];
      endfunction

      // Note one accepted request; a terminator queues the saturated value
      function void take_unit(logic [15:0] unit_code);
         int          d;
         logic [31:0] low_word;
         if (unit_code == wdsi_pkg::CODE_NUL) begin
            low_word = magnitude[31:0];
            if (minus_seen)
               pending_values.push_back((magnitude >= wdsi_pkg::NEG_LIMIT) ?
                                        wdsi_pkg::RESULT_MIN : ~low_word + 32'd1);
            else
               pending_values.push_back((magnitude > wdsi_pkg::POS_LIMIT) ?
                                        wdsi_pkg::RESULT_MAX : low_word);
            clear_parse();
            return;
         end
         d = digit_value(unit_code);
         case (parse_phase)
            wdsi_pkg::PHASE_SKIP: begin
               if (is_blank(unit_code)) begin
                  // still in leading whitespace
               end else if (unit_code == wdsi_pkg::CODE_MINUS) begin
                  minus_seen  = 1'b1;
                  parse_phase = wdsi_pkg::PHASE_DIGITS;
               end else if (unit_code == wdsi_pkg::CODE_PLUS) begin
                  parse_phase = wdsi_pkg::PHASE_DIGITS;
               end else if (d >= 0) begin
                  add_digit(d);
                  parse_phase = wdsi_pkg::PHASE_DIGITS;
               end else begin
                  parse_phase = wdsi_pkg::PHASE_DONE;
               end
            end
            wdsi_pkg::PHASE_DIGITS: begin
               if (d >= 0) add_digit(d);
               else parse_phase = wdsi_pkg::PHASE_DONE;
            end
            default: ; // rest of string ignored until terminator
         endcase
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatch_count++;
      endtask

      task check_value(logic [31:0] got);
         logic [31:0] want;
         if (pending_values.size() == 0) begin
            report_mismatch($sformatf("unexpected value %0d", $signed(got)));
         end else begin
            want = pending_values.pop_front();
            if (got !== want)
               report_mismatch($sformatf("value got %0d expected %0d",
                                         $signed(got), $signed(want)));
         end
      endtask

      function int pending();
         return pending_values.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [15:0]        req_code_unit;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_value;

   parse_checker board = new();

   int sender_idle_pct;
   int receiver_idle_pct;
   int units_sent;
   bit hold_start;
   int hold_count;

   wide_decimal_string_to_int_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_unit (req_code_unit),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value)
   );

   always #2 clock = ~clock;

   // Run limit, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("** wide_decimal_string_to_int_core: FAILED **");
      $finish;
   end

   // Receiver: random ready, or a long counted hold-off when asked
   initial begin
      rsp_ready  = 1'b0;
      hold_count = 0;
      forever begin
         @(negedge clock);
         if (hold_count > 0) begin
            rsp_ready <= 1'b0;
            hold_count--;
         end else if (hold_start) begin
            hold_start = 1'b0;
            hold_count = 300;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // Result check at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_value(rsp_value);
   end

   function automatic logic [15:0] digit_unit(int d, int blk);
      return wdsi_pkg::DIGIT_BASE[blk] + 16'(d);
   endfunction

   function automatic logic [15:0] any_blank();
      return wdsi_pkg::SPACE_UNIT[$urandom_range(wdsi_pkg::NUM_SPACE_UNITS - 1)];
   endfunction

   // Offer one request at a falling edge and hold it until taken
   task automatic send_unit(logic [15:0] unit_code, bit counted = 1'b1);
      req_valid     <= 1'b1;
      req_code_unit <= unit_code;
      do @(posedge clock); while (!req_ready);
      board.take_unit(unit_code);
      if (counted) units_sent++;
      @(negedge clock);
      // Idle cycles at the configured rate
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   // ASCII text with digits mapped to a block (negative block: mixed), then terminator
   task automatic send_text(string s, int blk);
      byte c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (c >= "0" && c <= "9")
            send_unit(digit_unit(c - "0",
                                 (blk < 0) ? $urandom_range(wdsi_pkg::NUM_DIGIT_BLOCKS - 1)
                                           : blk));
         else
            send_unit({8'h00, c});
      end
      send_unit(wdsi_pkg::CODE_NUL);
   endtask

   // Sender pauses until every queued value has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (board.pending() > 0) @(negedge clock);
   endtask

   // One random string: mostly well formed, some noise and broken prefixes
   task automatic send_random_string();
      logic [15:0] text[$];
      logic [15:0] trailer[$];
      string       edge_cases[6];
      string       pick_str;
      int          kind;
      int          n;
      int          blk;
      bit          mix;
      edge_cases = '{"2147483647", "2147483648", "2147483649", "4294967295",
                     "4294967296", "0000000000012"};
      kind = $urandom_range(99);
      blk  = $urandom_range(wdsi_pkg::NUM_DIGIT_BLOCKS - 1);
      mix  = ($urandom_range(3) == 0);
      if (kind < 12) begin
         // noise: any mix of units
         n = $urandom_range(6, 1);
         repeat (n) begin
            case ($urandom_range(3))
               0: text.push_back(16'($urandom_range(16'hFFFF, 1)));
               1: text.push_back(any_blank());
               2: text.push_back($urandom_range(1) ? wdsi_pkg::CODE_PLUS
                                                   : wdsi_pkg::CODE_MINUS);
               default: text.push_back(digit_unit($urandom_range(9), blk));
            endcase
         end
      end else begin
         n = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
         repeat (n) text.push_back(any_blank());
         case ($urandom_range(2))
            1: text.push_back(wdsi_pkg::CODE_PLUS);
            2: text.push_back(wdsi_pkg::CODE_MINUS);
            default: ;
         endcase
         // broken: whitespace or a minus sign right after the optional sign
         if (kind < 20) text.push_back($urandom_range(1) ? any_blank() : wdsi_pkg::CODE_MINUS);
         if (kind < 35) begin
            pick_str = edge_cases[$urandom_range(5)];
            for (int i = 0; i < pick_str.len(); i++)
               text.push_back(digit_unit(pick_str[i] - "0",
                                         mix ? $urandom_range(wdsi_pkg::NUM_DIGIT_BLOCKS - 1)
                                             : blk));
         end else begin
            n = ($urandom_range(8) == 0) ? $urandom_range(14, 11) : $urandom_range(10);
            repeat (n)
               text.push_back(digit_unit($urandom_range(9),
                                         mix ? $urandom_range(wdsi_pkg::NUM_DIGIT_BLOCKS - 1)
                                             : blk));
         end
         // trailing random units after the number, ignored by the parser unless they continue the digits
         if ($urandom_range(3) == 0) begin
            n = $urandom_range(3, 1);
            repeat (n) trailer.push_back(16'($urandom_range(16'hFFFF, 1)));
         end
      end
      foreach (text[i]) send_unit(text[i]);
      foreach (trailer[i]) send_unit(trailer[i], 1'b0);
      send_unit(wdsi_pkg::CODE_NUL);
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_code_unit     = '0;
      hold_start        = 1'b0;
      units_sent        = 0;
      sender_idle_pct   = 9;
      receiver_idle_pct = 68;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty, sign only, whitespace + sign + fullwidth digit,
      // negative limit with mixed blocks, ignored tail, second sign
      send_text("", 0);
      send_text("-", 0);
      send_unit(16'h3000);
      send_text("+9", wdsi_pkg::NUM_DIGIT_BLOCKS - 1);
      send_text("-2147483648", -1);
      send_unit(digit_unit(1, 0));
      send_unit(16'hFFFF);
      send_unit(wdsi_pkg::CODE_NUL);
      send_text("+-5", 0);
      wait_for_results();

      while (units_sent < 600) send_random_string();

      // Long receiver hold-off while requests keep coming
      hold_start = 1'b1;
      repeat (16) send_text("7", $urandom_range(wdsi_pkg::NUM_DIGIT_BLOCKS - 1));
      wait_for_results();

      sender_idle_pct   = 68;
      receiver_idle_pct = 9;
      while (units_sent < 1200) send_random_string();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      while (units_sent < 1800) send_random_string();

      wait_for_results();
      repeat (10) @(negedge clock);
      if (board.mismatch_count == 0 && board.pending() == 0)
         $display("** wide_decimal_string_to_int_core: PASSED **");
      else
         $display("** wide_decimal_string_to_int_core: FAILED **");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/wdsi_pkg.sv
rtl/wdsi_decode.sv
rtl/wdsi_accum.sv
rtl/wide_decimal_string_to_int_core.sv
bench/tb_top.sv
